/* rtl/tlfbs_pkg.sv */
// Shared types and constants of the two-level FCFS batch scheduler.
package tlfbs_pkg;

    localparam int unsigned TimeW = 16;
    localparam int unsigned FinW  = 23;
    localparam int unsigned SumW  = 29;
    localparam int unsigned IdxW  = 6;

    typedef struct packed {
        logic             cls;
        logic [TimeW-1:0] bur;
        logic [TimeW-1:0] arr;
    } t_job;

    typedef struct packed {
        logic load_wr;
        logic scan_issue;
        logic decide;
        logic emit_calc;
        logic emit_next;
        logic batch_clr;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic found;
        logic sched_done;
        logic out_last;
    } t_sts;

endpackage

/* rtl/tlfbs_ctrl.sv */
// Sequencer for loading, scheduling passes and result output.
module tlfbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_last_job,
    input  logic            i_out_ready,
    input  tlfbs_pkg::t_sts i_sts,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output tlfbs_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_ERD    = 3'd4;
    localparam logic [2:0] S_ECALC  = 3'd5;
    localparam logic [2:0] S_EOUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load_wr = i_valid;
                if (i_valid && i_last_job) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_sts.found && i_sts.sched_done) begin
                    n_state = S_ERD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_ERD: begin
                n_state = S_ECALC;
            end
            S_ECALC: begin
                o_cmd.emit_calc = 1'b1;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        o_cmd.batch_clr = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_EOUT);

endmodule

/* rtl/tlfbs_dp.sv */
// Job storage, selection scan, schedule clock and result arithmetic.
module tlfbs_dp #(
    parameter int unsigned MAX_JOBS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlfbs_pkg::t_cmd               i_cmd,
    input  logic [tlfbs_pkg::TimeW-1:0]   i_arrival_time,
    input  logic [tlfbs_pkg::TimeW-1:0]   i_burst_time,
    input  logic                          i_is_user,
    output tlfbs_pkg::t_sts               o_sts,
    output logic [tlfbs_pkg::IdxW-1:0]    o_job_index,
    output logic [tlfbs_pkg::FinW-1:0]    o_completion_time,
    output logic [tlfbs_pkg::FinW-1:0]    o_turnaround_time,
    output logic [tlfbs_pkg::FinW-1:0]    o_waiting_time,
    output logic [tlfbs_pkg::SumW-1:0]    o_sum_turnaround,
    output logic [tlfbs_pkg::SumW-1:0]    o_sum_waiting,
    output logic                          o_last_result
);

    localparam int unsigned IW = $clog2(MAX_JOBS);
    localparam int unsigned CW = $clog2(MAX_JOBS + 1);
    localparam int unsigned TW = tlfbs_pkg::TimeW;
    localparam int unsigned FW = tlfbs_pkg::FinW;
    localparam int unsigned SW = tlfbs_pkg::SumW;

    tlfbs_pkg::t_job mem_job [MAX_JOBS];
    logic [FW-1:0]   mem_fin [MAX_JOBS];

    logic [MAX_JOBS-1:0] r_done;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_sched;
    logic [IW-1:0]       r_idx;
    logic [FW-1:0]       r_clock;

    tlfbs_pkg::t_job r_rd_job;
    logic [FW-1:0]   r_rd_fin;
    logic            r_rd_done;
    logic [IW-1:0]   r_rd_idx;
    logic            r_cmp_vld;

    logic            r_found;
    logic            r_any;
    logic [IW-1:0]   r_pick;
    logic            r_pcls;
    logic [TW-1:0]   r_parr;
    logic [TW-1:0]   r_pbur;
    logic [TW-1:0]   r_next;

    logic [SW-1:0]   r_stat;
    logic [SW-1:0]   r_swt;

    logic            cand;
    logic            arrived;
    logic            better;
    logic            upd_next;
    logic            idx_last;
    logic [FW-1:0]   clock_run;
    logic [FW-1:0]   tat;
    logic [FW-1:0]   wt;
    logic [SW-1:0]   n_stat;
    logic [SW-1:0]   n_swt;

    assign cand     = r_cmp_vld && !r_rd_done;
    assign arrived  = {{(FW-TW){1'b0}}, r_rd_job.arr} <= r_clock;
    assign better   = cand && arrived && (!r_found || (r_rd_job.cls < r_pcls) ||
                      ((r_rd_job.cls == r_pcls) && (r_rd_job.arr < r_parr)));
    assign upd_next = cand && (!r_any || (r_rd_job.arr < r_next));
    assign idx_last = ({1'b0, r_idx} == (r_cnt - CW'(1)));
    assign clock_run = r_clock + {{(FW-TW){1'b0}}, r_pbur};

    assign tat    = r_rd_fin - {{(FW-TW){1'b0}}, r_rd_job.arr};
    assign wt     = tat - {{(FW-TW){1'b0}}, r_rd_job.bur};
    assign n_stat = r_stat + {{(SW-FW){1'b0}}, tat};
    assign n_swt  = r_swt + {{(SW-FW){1'b0}}, wt};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && (r_cnt < CW'(MAX_JOBS))) begin
            mem_job[r_cnt[IW-1:0]] <= '{cls: i_is_user, bur: i_burst_time,
                                        arr: i_arrival_time};
        end
        r_rd_job <= mem_job[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && r_found) begin
            mem_fin[r_pick] <= clock_run;
        end
        r_rd_fin <= mem_fin[r_idx];
    end

    always_ff @(posedge i_clk) begin
        r_rd_done <= r_done[r_idx];
        r_rd_idx  <= r_idx;
        if (better) begin
            r_pick <= r_rd_idx;
            r_pcls <= r_rd_job.cls;
            r_parr <= r_rd_job.arr;
            r_pbur <= r_rd_job.bur;
        end
        if (upd_next) begin
            r_next <= r_rd_job.arr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= '0;
            r_cnt     <= '0;
            r_sched   <= '0;
            r_idx     <= '0;
            r_clock   <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_any     <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_issue;
            if (better) begin
                r_found <= 1'b1;
            end
            if (cand) begin
                r_any <= 1'b1;
            end
            if (i_cmd.load_wr && (r_cnt < CW'(MAX_JOBS))) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.scan_issue || i_cmd.emit_next) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.decide) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                r_any   <= 1'b0;
                if (r_found) begin
                    r_clock        <= clock_run;
                    r_done[r_pick] <= 1'b1;
                    r_sched        <= r_sched + CW'(1);
                end else begin
                    r_clock <= {{(FW-TW){1'b0}}, r_next};
                end
            end
            if (i_cmd.batch_clr) begin
                r_done  <= '0;
                r_cnt   <= '0;
                r_sched <= '0;
                r_idx   <= '0;
                r_clock <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_stat <= '0;
            r_swt  <= '0;
        end else if (i_cmd.emit_calc) begin
            r_stat <= n_stat;
            r_swt  <= n_swt;
        end
        if (i_cmd.emit_calc) begin
            o_job_index       <= tlfbs_pkg::IdxW'(r_idx);
            o_completion_time <= r_rd_fin;
            o_turnaround_time <= tat;
            o_waiting_time    <= wt;
            o_sum_turnaround  <= idx_last ? n_stat : '0;
            o_sum_waiting     <= idx_last ? n_swt : '0;
            o_last_result     <= idx_last;
        end
    end

    assign o_sts.idx_last   = idx_last;
    assign o_sts.found      = r_found;
    assign o_sts.sched_done = ((r_sched + CW'(1)) == r_cnt);
    assign o_sts.out_last   = o_last_result;

endmodule

/* rtl/two_level_fcfs_batch_scheduler_unit.sv */
// Top level of the two-level FCFS batch scheduler.
// Loading takes one job beat per cycle; the beat with i_last_job starts the schedule.
// Each scheduling pass reads all n held jobs through one memory port, and a batch needs
// at most 2n passes (one pick per pass, plus clock jumps when idle).
// Results then leave in load order; each is held until i_ready, and the next is read only after that.
// Synchronous active-low reset empties the batch; job storage is not cleared.
module two_level_fcfs_batch_scheduler_unit #(
    parameter int unsigned MAX_JOBS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tlfbs_pkg::TimeW-1:0] i_arrival_time,
    input  logic [tlfbs_pkg::TimeW-1:0] i_burst_time,
    input  logic                        i_is_user,
    input  logic                        i_last_job,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tlfbs_pkg::IdxW-1:0]  o_job_index,
    output logic [tlfbs_pkg::FinW-1:0]  o_completion_time,
    output logic [tlfbs_pkg::FinW-1:0]  o_turnaround_time,
    output logic [tlfbs_pkg::FinW-1:0]  o_waiting_time,
    output logic [tlfbs_pkg::SumW-1:0]  o_sum_turnaround,
    output logic [tlfbs_pkg::SumW-1:0]  o_sum_waiting,
    output logic                        o_last_result
);

    tlfbs_pkg::t_cmd cmd;
    tlfbs_pkg::t_sts sts;

    tlfbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_job  (i_last_job),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    tlfbs_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_arrival_time    (i_arrival_time),
        .i_burst_time      (i_burst_time),
        .i_is_user         (i_is_user),
        .o_sts             (sts),
        .o_job_index       (o_job_index),
        .o_completion_time (o_completion_time),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time),
        .o_sum_turnaround  (o_sum_turnaround),
        .o_sum_waiting     (o_sum_waiting),
        .o_last_result     (o_last_result)
    );

    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("Input accepted while a result is pending.");

    a_reload_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_result) |=> o_ready)
        else $error("Block did not return to loading after the final result.");

    a_no_result_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_valid)
        else $error("Result appeared directly after a load beat.");

    a_gap_between_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_result) |=> !o_valid)
        else $error("Result repeated without a fresh read.");

endmodule
